### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the port-level checker module.
// Each macro expects signals named clk and arst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PF_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PF_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

### rtl/core/pf_pkg.sv
// ----------------------------------------------------------------------------
// pf_pkg
// Types, constants and helper functions shared by the Playfair digraph
// cipher pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pf_pkg;

	// Key square geometry and letter coding.
	localparam int SqDim   = 5;
	localparam int SqLast  = SqDim - 1;
	localparam int LetterW = 5;
	localparam int IdxW    = 3;
	localparam int RowW    = SqDim * LetterW;
	localparam int CellN   = SqDim * SqDim;
	localparam int CfgIdxW = 3;

	typedef logic [LetterW-1:0] letter_t;
	typedef logic [IdxW-1:0]    idx_t;
	typedef letter_t [SqDim-1:0] row_t;
	typedef row_t [SqDim-1:0]    square_t;
	typedef logic [CellN-1:0]   hit_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	// Register indexes of the configuration port. Rows take indexes 0 to 4.
	localparam cfg_idx_t RegDecrypt = cfg_idx_t'(SqDim);

	// Letter codes folded together on lookup.
	localparam letter_t CodeI = letter_t'(8);
	localparam letter_t CodeJ = letter_t'(9);

	// Square after reset: a b c d e / f g h i k / l m n o p / q r s t u / v w x y z.
	localparam square_t SquareReset = {
		25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
	};

	// Position of one letter in the square.
	typedef struct packed {
		idx_t row;
		idx_t col;
	} pos_t;

	// Result of a square search for one letter.
	typedef struct packed {
		logic found;
		pos_t pos;
	} find_t;

	// Positions of both letters of a pair, with the missing-letter flag.
	typedef struct packed {
		pos_t a;
		pos_t b;
		logic missing;
	} pair_loc_t;

	// One step along a row or column with wrap, forward or backward.
	function automatic idx_t step_idx(input idx_t v, input logic back);
		if (back) begin
			return (v == '0) ? idx_t'(SqLast) : v - idx_t'(1);
		end else begin
			return (v == idx_t'(SqLast)) ? '0 : v + idx_t'(1);
		end
	endfunction

endpackage

`default_nettype wire

### rtl/core/pf_locate.sv
// ----------------------------------------------------------------------------
// pf_locate
// First two pipeline stages: compare both letters against every square cell,
// then encode the first match of each letter into a row and column.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_locate (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pf_pkg::letter_t   first_letter,
	input  pf_pkg::letter_t   second_letter,
	input  pf_pkg::square_t   square,
	output logic              out_valid,
	input  logic              out_ready,
	output pf_pkg::pair_loc_t loc
);
	import pf_pkg::*;

	letter_t   key_a;
	letter_t   key_b;
	hit_t      hit_a;
	hit_t      hit_b;
	hit_t      hit_a_s1;
	hit_t      hit_b_s1;
	logic      valid_s1;
	logic      valid_s2;
	logic      ready_s2;
	find_t     find_a;
	find_t     find_b;
	pair_loc_t loc_s2;

	// Lowest match in row-major order: lowest column per row, then lowest row.
	function automatic find_t find_first(input hit_t h);
		find_t            f;
		logic [SqDim-1:0] row_any;
		idx_t             row_col [SqDim];
		f = '0;
		for (int r = 0; r < SqDim; r++) begin
			row_any[r] = 1'b0;
			row_col[r] = '0;
			for (int c = SqDim - 1; c >= 0; c--) begin
				if (h[r * SqDim + c]) begin
					row_any[r] = 1'b1;
					row_col[r] = idx_t'(c);
				end
			end
		end
		for (int r = SqDim - 1; r >= 0; r--) begin
			if (row_any[r]) begin
				f.found   = 1'b1;
				f.pos.row = idx_t'(r);
				f.pos.col = row_col[r];
			end
		end
		return f;
	endfunction

	// Stage handshake: a stage takes new data when empty or when it drains.
	assign ready_s2  = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || ready_s2;
	assign out_valid = valid_s2;
	assign loc       = loc_s2;

	// Fold j onto i and compare against all cells in parallel.
	always_comb begin
		key_a = (first_letter == CodeJ) ? CodeI : first_letter;
		key_b = (second_letter == CodeJ) ? CodeI : second_letter;
		for (int r = 0; r < SqDim; r++) begin
			for (int c = 0; c < SqDim; c++) begin
				hit_a[r * SqDim + c] = (square[r][c] == key_a);
				hit_b[r * SqDim + c] = (square[r][c] == key_b);
			end
		end
	end

	// Encode the match vectors of stage 1.
	always_comb begin
		find_a = find_first(hit_a_s1);
		find_b = find_first(hit_b_s1);
	end

	// Valid bits of both stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers of both stages.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hit_a_s1 <= hit_a;
			hit_b_s1 <= hit_b;
		end
		if (ready_s2 && valid_s1) begin
			loc_s2.a       <= find_a.pos;
			loc_s2.b       <= find_b.pos;
			loc_s2.missing <= !find_a.found || !find_b.found;
		end
	end

endmodule

`default_nettype wire

### rtl/core/pf_rule.sv
// ----------------------------------------------------------------------------
// pf_rule
// Third pipeline stage: applies the same-row, same-column or rectangle rule
// to the two letter positions and registers the target positions.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_rule (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pf_pkg::pair_loc_t in_loc,
	input  logic              decrypt_mode,
	output logic              out_valid,
	input  logic              out_ready,
	output pf_pkg::pair_loc_t loc
);
	import pf_pkg::*;

	pair_loc_t next_loc;
	pair_loc_t loc_s3;
	logic      valid_s3;

	assign in_ready  = !valid_s3 || out_ready;
	assign out_valid = valid_s3;
	assign loc       = loc_s3;

	// Target positions; a missing letter passes through untouched.
	always_comb begin
		next_loc = in_loc;
		if (!in_loc.missing) begin
			if (in_loc.a.row == in_loc.b.row) begin
				next_loc.a.col = step_idx(in_loc.a.col, decrypt_mode);
				next_loc.b.col = step_idx(in_loc.b.col, decrypt_mode);
			end else if (in_loc.a.col == in_loc.b.col) begin
				next_loc.a.row = step_idx(in_loc.a.row, decrypt_mode);
				next_loc.b.row = step_idx(in_loc.b.row, decrypt_mode);
			end else begin
				next_loc.a.col = in_loc.b.col;
				next_loc.b.col = in_loc.a.col;
			end
		end
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			loc_s3 <= next_loc;
		end
	end

endmodule

`default_nettype wire

### rtl/core/pf_lookup.sv
// ----------------------------------------------------------------------------
// pf_lookup
// Output stage: reads the two target cells from the square and holds the
// result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_lookup (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pf_pkg::pair_loc_t in_loc,
	input  pf_pkg::square_t   square,
	output logic              out_valid,
	input  logic              out_ready,
	output pf_pkg::letter_t   out_first,
	output pf_pkg::letter_t   out_second,
	output logic              letter_missing
);
	import pf_pkg::*;

	letter_t cell_a;
	letter_t cell_b;
	letter_t first_s4;
	letter_t second_s4;
	logic    missing_s4;
	logic    valid_s4;

	assign in_ready       = !valid_s4 || out_ready;
	assign out_valid      = valid_s4;
	assign out_first      = first_s4;
	assign out_second     = second_s4;
	assign letter_missing = missing_s4;

	// Cell reads; a missing letter forces both outputs to zero.
	always_comb begin
		cell_a = square[in_loc.a.row][in_loc.a.col];
		cell_b = square[in_loc.b.row][in_loc.b.col];
		if (in_loc.missing) begin
			cell_a = '0;
			cell_b = '0;
		end
	end

	// Output valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			first_s4   <= cell_a;
			second_s4  <= cell_b;
			missing_s4 <= in_loc.missing;
		end
	end

endmodule

`default_nettype wire

### rtl/core/playfair_digraph_cipher.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Playfair digraph cipher: enciphers or deciphers one letter pair per cycle,
// unless the receiver stalls, against a configurable 5x5 key square.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one letter pair per transfer,
// codes 0 to 25, with j looked up as i. The output channel
// (out_valid/out_ready) returns one result per input pair, in order.
// The configuration channel (cfg_valid/cfg_ready) writes square rows 0 to 4
// at indexes 0 to 4 and the decrypt mode at index 5; other indexes are
// ignored. cfg_ready is always high. Write it only while no pair is in flight.
// A pair passes in order through the four register stages (cell compare,
// match encode, rule, cell read) before it leaves. Throughput is one pair
// per cycle while the receiver does not stall.
// When the receiver stalls, each stage holds its item, bubbles in front of
// it fill up, and in_ready falls only once every stage is occupied.
// Reset empties the pipeline and loads the square a..z without j and
// encipher mode.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_cipher (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pf_pkg::letter_t  first_letter,
	input  pf_pkg::letter_t  second_letter,
	output logic             out_valid,
	input  logic             out_ready,
	output pf_pkg::letter_t  out_first,
	output pf_pkg::letter_t  out_second,
	output logic             letter_missing,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  pf_pkg::cfg_idx_t cfg_index,
	input  logic [pf_pkg::RowW-1:0] cfg_data
);
	import pf_pkg::*;

	square_t   square_q;
	logic      decrypt_mode_q;
	logic      loc_valid;
	logic      loc_ready;
	pair_loc_t loc;
	logic      tgt_valid;
	logic      tgt_ready;
	pair_loc_t tgt;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_q       <= SquareReset;
			decrypt_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index < cfg_idx_t'(SqDim)) begin
				square_q[cfg_index] <= row_t'(cfg_data);
			end else if (cfg_index == RegDecrypt) begin
				decrypt_mode_q <= cfg_data[0];
			end
		end
	end

	// Stages 1 and 2: compare and encode.
	pf_locate u_locate (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_letter (first_letter),
		.second_letter(second_letter),
		.square       (square_q),
		.out_valid    (loc_valid),
		.out_ready    (loc_ready),
		.loc          (loc)
	);

	// Stage 3: cipher rule.
	pf_rule u_rule (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (loc_valid),
		.in_ready    (loc_ready),
		.in_loc      (loc),
		.decrypt_mode(decrypt_mode_q),
		.out_valid   (tgt_valid),
		.out_ready   (tgt_ready),
		.loc         (tgt)
	);

	// Stage 4: cell read and output register.
	pf_lookup u_lookup (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (tgt_valid),
		.in_ready      (tgt_ready),
		.in_loc        (tgt),
		.square        (square_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_first     (out_first),
		.out_second    (out_second),
		.letter_missing(letter_missing)
	);

endmodule

`default_nettype wire

### rtl/core/pf_port_chk.sv
// ----------------------------------------------------------------------------
// pf_port_chk
// Port-level checks of the Playfair digraph cipher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pf_port_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input pf_pkg::letter_t out_first,
	input pf_pkg::letter_t out_second,
	input logic            letter_missing,
	input logic            cfg_valid,
	input logic            cfg_ready
);

	// A stalled result keeps its payload until the transfer.
	`PF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_first) && $stable(out_second) && $stable(letter_missing))

	// A missing letter always comes with a zero pair.
	`PF_ASSERT_IMP(a_missing_zero, out_valid && letter_missing, out_first == '0 && out_second == '0)

	// The input side only backs up when a result is waiting at the output.
	`PF_ASSERT_IMP(a_stall_source, !in_ready, out_valid && !out_ready)

	// Configuration writes are never refused.
	`PF_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind playfair_digraph_cipher pf_port_chk u_port_chk (.*);

`default_nettype wire

### test/playfair_digraph_cipher_checker.sv
// ----------------------------------------------------------------------------
// Playfair digraph cipher checker
// Watches the configuration, input and output channels of the cipher. It keeps
// its own copy of the key square and the mode, works out the expected pair for
// every input transfer and compares each output transfer with the oldest
// outstanding prediction. It hands a failure count and the number of
// outstanding predictions to the testbench top.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  pf_pkg::letter_t         first_letter,
	input  pf_pkg::letter_t         second_letter,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  pf_pkg::letter_t         out_first,
	input  pf_pkg::letter_t         out_second,
	input  logic                    letter_missing,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  pf_pkg::cfg_idx_t        cfg_index,
	input  logic [pf_pkg::RowW-1:0] cfg_data,
	output int                      fault_count,
	output int                      pairs_in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	import pf_pkg::*;

	// One predicted result, with the pair that caused it for reporting.
	typedef struct packed {
		letter_t src_first;
		letter_t src_second;
		letter_t first;
		letter_t second;
		logic    missing;
	} digraph_t;

	square_t  key_square;
	logic     deciphering;
	digraph_t cipher_q[$];

	// Finds a letter in row-major order; j is looked up as i.
	function automatic bit find_letter(input square_t sq, input letter_t code,
			output int row, output int col);
		letter_t key;
		bit      hit;
		key = (code == CodeJ) ? CodeI : code;
		hit = 1'b0;
		row = 0;
		col = 0;
		for (int r = 0; r < SqDim; r++) begin
			for (int c = 0; c < SqDim; c++) begin
				if (!hit && sq[r][c] == key) begin
					hit = 1'b1;
					row = r;
					col = c;
				end
			end
		end
		return hit;
	endfunction

	// Moves one place along a row or column, wrapping at either end.
	function automatic int wrap_move(input int v, input logic back);
		return back ? (v + SqLast) % SqDim : (v + 1) % SqDim;
	endfunction

	// Enciphers or deciphers one pair against the current square.
	function automatic digraph_t cipher_pair(input square_t sq, input logic back,
			input letter_t a, input letter_t b);
		digraph_t res;
		int       r1, c1, r2, c2;
		bit       hit1, hit2;
		res = '0;
		res.src_first = a;
		res.src_second = b;
		hit1 = find_letter(sq, a, r1, c1);
		hit2 = find_letter(sq, b, r2, c2);
		if (!hit1 || !hit2) begin
			res.missing = 1'b1;
		end else if (r1 == r2) begin
			res.first = sq[r1][wrap_move(c1, back)];
			res.second = sq[r2][wrap_move(c2, back)];
		end else if (c1 == c2) begin
			res.first = sq[wrap_move(r1, back)][c1];
			res.second = sq[wrap_move(r2, back)][c2];
		end else begin
			res.first = sq[r1][c2];
			res.second = sq[r2][c1];
		end
		return res;
	endfunction

	// Tracks register writes, predicts each input transfer and checks each
	// output transfer in order.
	always @(posedge clk or negedge arst_n) begin
		digraph_t want;
		if (!arst_n) begin
			key_square = SquareReset;
			deciphering = 1'b0;
			cipher_q.delete();
			fault_count = 0;
			pairs_in_flight = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < RegDecrypt) begin
					key_square[cfg_index] = row_t'(cfg_data);
				end else if (cfg_index == RegDecrypt) begin
					deciphering = cfg_data[0];
				end
			end
			if (in_valid && in_ready) begin
				cipher_q.push_back(cipher_pair(key_square, deciphering,
					first_letter, second_letter));
			end
			if (out_valid && out_ready) begin
				if (cipher_q.size() == 0) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("%0t checker: unexpected result %0d %0d missing=%0b",
							$time, out_first, out_second, letter_missing);
					end
				end else begin
					want = cipher_q.pop_front();
					if (out_first !== want.first || out_second !== want.second ||
							letter_missing !== want.missing) begin
						fault_count++;
						if (fault_count <= 10) begin
							$display("%0t checker: pair %0d %0d expected %0d %0d missing=%0b, got %0d %0d missing=%0b",
								$time, want.src_first, want.src_second, want.first,
								want.second, want.missing, out_first, out_second,
								letter_missing);
						end
					end
				end
			end
			pairs_in_flight = cipher_q.size();
		end
	end

endmodule

### test/playfair_digraph_cipher_tb.sv
// ----------------------------------------------------------------------------
// Playfair digraph cipher testbench
// Drives letter pairs and register writes into the cipher with random idle
// gaps on the sender and random stalls on the receiver. A directed part covers
// the row, column and rectangle rules, wrap, j folding, missing letters and
// odd squares; random phases then load new squares and modes and send
// mostly well-formed pairs. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pf_pkg::*;

	localparam cfg_idx_t RegSpareLo = cfg_idx_t'(SqDim + 1);
	localparam cfg_idx_t RegSpareHi = '1;
	localparam int PhaseCount = 10;
	localparam int PairsPerPhase = 200;
	localparam int SettleCycles = 8;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	letter_t           first_letter;
	letter_t           second_letter;
	logic              out_valid;
	logic              out_ready;
	letter_t           out_first;
	letter_t           out_second;
	logic              letter_missing;
	logic              cfg_valid;
	logic              cfg_ready;
	cfg_idx_t          cfg_index;
	logic [RowW-1:0]   cfg_data;
	int                fault_count;
	int                pairs_in_flight;

	// Stimulus-side copy of the square, used to pick letters that are present.
	square_t           key_sq;
	bit                tx_idle_on;
	bit                rx_stall_on;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	playfair_digraph_cipher dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.first_letter   (first_letter),
		.second_letter  (second_letter),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_first      (out_first),
		.out_second     (out_second),
		.letter_missing (letter_missing),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	playfair_digraph_cipher_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.first_letter    (first_letter),
		.second_letter   (second_letter),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_first       (out_first),
		.out_second      (out_second),
		.letter_missing  (letter_missing),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fault_count     (fault_count),
		.pairs_in_flight (pairs_in_flight)
	);

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end else if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 20);
	endfunction

	// Sends one pair, after an optional idle gap, and waits for its transfer.
	// Every call starts and ends at a falling edge.
	task automatic send_pair(input letter_t a, input letter_t b);
		int gap;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		first_letter = a;
		second_letter = b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Holds the input side idle until every pair has come back.
	task automatic drain_pairs();
		in_valid = 1'b0;
		while (pairs_in_flight != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	// One register write transfer.
	task automatic write_reg(input cfg_idx_t idx, input logic [RowW-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Loads the whole square and the mode; the block must be idle.
	task automatic load_setup(input square_t sq, input logic back);
		drain_pairs();
		key_sq = sq;
		for (int r = 0; r < SqDim; r++) begin
			write_reg(cfg_idx_t'(r), sq[r]);
		end
		write_reg(RegDecrypt, RowW'(back));
	endtask

	// Builds a shuffled square of the 25 letters without j, then spoils a few
	// cells when asked: duplicates, j itself or codes above z.
	function automatic square_t shuffled_square(input int spoil);
		int      letters[25];
		int      k, pick, hold;
		square_t sq;
		k = 0;
		for (int v = 0; v < 26; v++) begin
			if (v != int'(CodeJ)) begin
				letters[k] = v;
				k++;
			end
		end
		for (int i = 24; i > 0; i--) begin
			pick = $urandom_range(0, i);
			hold = letters[i];
			letters[i] = letters[pick];
			letters[pick] = hold;
		end
		for (int i = 0; i < 25; i++) begin
			sq[i / SqDim][i % SqDim] = letter_t'(letters[i]);
		end
		for (int i = 0; i < spoil; i++) begin
			sq[$urandom_range(0, SqLast)][$urandom_range(0, SqLast)] =
				letter_t'($urandom_range(0, 31));
		end
		return sq;
	endfunction

	// Picks a pair: mostly letters from the square, biased toward the same
	// row or column, with some raw codes over the whole field range.
	task automatic next_pair(output letter_t a, output letter_t b);
		int r, c, roll;
		r = $urandom_range(0, SqLast);
		c = $urandom_range(0, SqLast);
		roll = $urandom_range(0, 99);
		a = key_sq[r][c];
		if (roll < 25) begin
			b = key_sq[r][$urandom_range(0, SqLast)];
		end else if (roll < 50) begin
			b = key_sq[$urandom_range(0, SqLast)][c];
		end else if (roll < 80) begin
			b = key_sq[$urandom_range(0, SqLast)][$urandom_range(0, SqLast)];
		end else begin
			a = letter_t'($urandom_range(0, 31));
			b = letter_t'($urandom_range(0, 31));
		end
		if (a == CodeI && $urandom_range(0, 1) == 1) begin
			a = CodeJ;
		end
		if (b == CodeI && $urandom_range(0, 1) == 1) begin
			b = CodeJ;
		end
	endtask

	// Receiver: runs of ready broken by random stalls.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			out_ready = 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			if (rx_stall_on) begin
				out_ready = 1'b0;
				repeat (pick_gap()) @(negedge clk);
			end
		end
	end

	// Ends a run that hangs.
	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// Reset, directed pairs, random phases and the verdict.
	initial begin
		square_t sq;
		letter_t a, b;
		int      kind;
		arst_n = 1'b0;
		in_valid = 1'b0;
		first_letter = '0;
		second_letter = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		key_sq = SquareReset;
		tx_idle_on = 1'b1;
		rx_stall_on = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset square, enciphering: row, row wrap, column, column wrap,
		// rectangle, equal letters, j folding, codes above z.
		send_pair(5'd0, 5'd2);
		send_pair(5'd3, 5'd4);
		send_pair(5'd0, 5'd5);
		send_pair(5'd21, 5'd0);
		send_pair(5'd0, 5'd25);
		send_pair(5'd0, 5'd0);
		send_pair(5'd9, 5'd10);
		send_pair(5'd26, 5'd0);
		send_pair(5'd0, 5'd31);
		send_pair(5'd25, 5'd25);
		send_pair(5'd31, 5'd31);

		// Same square deciphering; writes to unused indexes must change nothing.
		load_setup(SquareReset, 1'b1);
		write_reg(RegSpareLo, '1);
		write_reg(RegSpareHi, '0);
		send_pair(5'd1, 5'd3);
		send_pair(5'd0, 5'd4);
		send_pair(5'd5, 5'd0);
		send_pair(5'd0, 5'd21);
		send_pair(5'd0, 5'd24);
		send_pair(5'd9, 5'd9);

		// Square of all ones: code 31 is found everywhere at the first cell.
		load_setup('1, 1'b0);
		send_pair(5'd31, 5'd31);
		send_pair(5'd31, 5'd0);

		// Square of all zeros: j folds to i, which is missing.
		load_setup('0, 1'b1);
		send_pair(5'd0, 5'd0);
		send_pair(5'd9, 5'd0);

		// Random phases, each with a fresh square and mode.
		for (int p = 0; p < PhaseCount; p++) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				sq = shuffled_square(0);
			end else if (kind < 9) begin
				sq = shuffled_square($urandom_range(1, 3));
			end else begin
				for (int r = 0; r < SqDim; r++) begin
					sq[r] = row_t'($urandom_range(0, 32'h1FF_FFFF));
				end
			end
			load_setup(sq, p % 2 == 1);
			tx_idle_on = (p % 3 != 0);
			rx_stall_on = (p % 4 != 1);
			for (int i = 0; i < PairsPerPhase; i++) begin
				next_pair(a, b);
				send_pair(a, b);
			end
		end

		// Let the last results come back, then give the verdict.
		drain_pairs();
		repeat (SettleCycles) @(posedge clk);
		if (fault_count == 0 && pairs_in_flight == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
